### hdl/bmc_pkg.sv
`timescale 1ns / 1ps

package bmc_pkg;

	localparam int ROW_W     = 16;
	localparam int CNT_W     = 5;
	localparam int MODE_W    = 2;
	localparam int IDX_W     = 4;
	localparam int CFG_IDX_W = 2;

	typedef logic [ROW_W-1:0]     row_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [MODE_W-1:0]    mode_t;
	typedef logic [IDX_W-1:0]     ridx_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_ROW_COUNT    = 2'd0;
	localparam cfg_idx_t CFG_COL_COUNT    = 2'd1;
	localparam cfg_idx_t CFG_CLOSURE_MODE = 2'd2;

	localparam mode_t MODE_TRANSITIVE = 2'd0;
	localparam mode_t MODE_REFLEXIVE  = 2'd1;
	localparam mode_t MODE_BOTH       = 2'd2;

	localparam cnt_t CNT_RESET = 5'd16;

	// geometry and mode of the matrix, as seen by the engine
	typedef struct packed {
		cnt_t rows;
		cnt_t diag;
		row_t cmask;
		logic refl;
		logic trans;
	} geom_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_PREP,
		ST_PDRAIN,
		ST_PIVOT,
		ST_STREAM,
		ST_SDRAIN,
		ST_OUT_RD,
		ST_OUT_CAP
	} state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_PREP,
		OP_PIVOT,
		OP_STREAM,
		OP_EMIT
	} op_t;

	function automatic cnt_t clamp_cnt(cnt_t v, cnt_t lim);
		cnt_t r;
		r = v;
		if (v == '0) r = cnt_t'(1);
		else if (v > lim) r = lim;
		return r;
	endfunction

endpackage

### hdl/bmc_if.sv
`timescale 1ns / 1ps

interface bmc_row_in_if;
	import bmc_pkg::*;
	logic valid;
	logic ready;
	row_t row_bits;
	logic last_row;

	modport source (output valid, output row_bits, output last_row, input ready);
	modport sink (input valid, input row_bits, input last_row, output ready);
endinterface

interface bmc_row_out_if;
	import bmc_pkg::*;
	logic  valid;
	logic  ready;
	ridx_t row_index;
	row_t  closed_bits;
	logic  final_row;

	modport source (output valid, output row_index, output closed_bits, output final_row,
		input ready);
	modport sink (input valid, input row_index, input closed_bits, input final_row,
		output ready);
endinterface

interface bmc_cfg_if;
	import bmc_pkg::*;
	logic     valid;
	logic     ready;
	cfg_idx_t index;
	cnt_t     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/bmc_ram.sv
`timescale 1ns / 1ps

module bmc_ram #(
	parameter int DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  bmc_pkg::row_t              wdata,
	input  logic                       re,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output bmc_pkg::row_t              rdata
);
	import bmc_pkg::*;

	row_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hdl/bmc_cfg.sv
`timescale 1ns / 1ps

module bmc_cfg #(
	parameter int DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	bmc_cfg_if.sink       cfg,
	output bmc_pkg::geom_t geom
);
	import bmc_pkg::*;

	cnt_t  row_count_q;
	cnt_t  col_count_q;
	mode_t mode_q;
	cnt_t  rows;
	cnt_t  cols;
	logic [ROW_W:0] mask_wide;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= CNT_RESET;
			col_count_q <= CNT_RESET;
			mode_q      <= MODE_TRANSITIVE;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_ROW_COUNT:    row_count_q <= cfg.data;
				CFG_COL_COUNT:    col_count_q <= cfg.data;
				CFG_CLOSURE_MODE: mode_q      <= cfg.data[MODE_W-1:0];
				default:          ;
			endcase
		end
	end

	always_comb begin
		rows       = clamp_cnt(row_count_q, cnt_t'(DEPTH));
		cols       = clamp_cnt(col_count_q, cnt_t'(DEPTH));
		mask_wide  = ((ROW_W+1)'(1) << cols) - (ROW_W+1)'(1);
		geom.rows  = rows;
		geom.diag  = (rows < cols) ? rows : cols;
		geom.cmask = mask_wide[ROW_W-1:0];
		// an unused mode code acts as reflexive then transitive
		geom.refl  = (mode_q != MODE_TRANSITIVE);
		geom.trans = (mode_q != MODE_REFLEXIVE);
	end

endmodule

### hdl/bmc_engine.sv
`timescale 1ns / 1ps

module bmc_engine #(
	parameter int DEPTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  bmc_pkg::geom_t geom,
	bmc_row_in_if.sink     row_in,
	bmc_row_out_if.source  row_out
);
	import bmc_pkg::*;

	localparam int AW = $clog2(DEPTH);

	state_t state_q, state_d;
	cnt_t   fill_q, cnt_q, piv_q;
	op_t    op, op_s1;
	logic [AW-1:0] addr_s1;
	row_t   prow_q;

	logic   out_vld_q;
	ridx_t  out_idx_q;
	row_t   out_bits_q;
	logic   out_final_q;

	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	row_t          wdata, rdata;

	logic in_acc, load_we, last_cnt;
	row_t prep_row, diag_bit;

	bmc_ram #(.DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign in_acc   = row_in.valid && row_in.ready;
	assign load_we  = in_acc && (fill_q < geom.rows);
	assign last_cnt = (cnt_q == geom.rows - cnt_t'(1));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD:    if (in_acc && row_in.last_row) state_d = ST_PREP;
			ST_PREP:    if (last_cnt) state_d = ST_PDRAIN;
			ST_PDRAIN:  state_d = geom.trans ? ST_PIVOT : ST_OUT_RD;
			ST_PIVOT:   state_d = ST_STREAM;
			ST_STREAM:  if (last_cnt) state_d = ST_SDRAIN;
			ST_SDRAIN:  state_d = (piv_q == geom.diag - cnt_t'(1)) ? ST_OUT_RD : ST_PIVOT;
			ST_OUT_RD:  if (!out_vld_q || row_out.ready) state_d = ST_OUT_CAP;
			ST_OUT_CAP: state_d = last_cnt ? ST_LOAD : ST_OUT_RD;
			default:    state_d = ST_LOAD;
		endcase
	end

	// read issue and handshake
	always_comb begin
		re           = 1'b0;
		raddr        = cnt_q[AW-1:0];
		op           = OP_NONE;
		row_in.ready = 1'b0;
		case (state_q)
			ST_LOAD: row_in.ready = 1'b1;
			ST_PREP: begin
				re = 1'b1;
				op = OP_PREP;
			end
			ST_PIVOT: begin
				re    = 1'b1;
				raddr = piv_q[AW-1:0];
				op    = OP_PIVOT;
			end
			ST_STREAM: begin
				re = 1'b1;
				op = OP_STREAM;
			end
			ST_OUT_RD: begin
				if (!out_vld_q || row_out.ready) begin
					re = 1'b1;
					op = OP_EMIT;
				end
			end
			default: ;
		endcase
	end

	// write-back: loaded rows, then modified rows in the cycle after their read
	always_comb begin
		diag_bit = row_t'(1) << addr_s1;
		prep_row = ((cnt_t'(addr_s1) < fill_q) ? rdata : '0)
			| ((geom.refl && (cnt_t'(addr_s1) < geom.diag)) ? diag_bit : '0);
		we    = 1'b0;
		waddr = addr_s1;
		wdata = rdata | prow_q;
		if (load_we) begin
			we    = 1'b1;
			waddr = fill_q[AW-1:0];
			wdata = row_in.row_bits & geom.cmask;
		end else begin
			case (op_s1)
				OP_PREP: begin
					we    = 1'b1;
					wdata = prep_row;
				end
				OP_STREAM: we = rdata[piv_q[IDX_W-1:0]];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			fill_q  <= '0;
			cnt_q   <= '0;
			piv_q   <= '0;
			op_s1   <= OP_NONE;
		end else begin
			state_q <= state_d;
			op_s1   <= op;
			case (state_q)
				ST_LOAD: begin
					if (load_we) fill_q <= fill_q + cnt_t'(1);
					cnt_q <= '0;
					piv_q <= '0;
				end
				ST_PREP, ST_STREAM: cnt_q <= cnt_q + cnt_t'(1);
				ST_PDRAIN, ST_PIVOT: cnt_q <= '0;
				ST_SDRAIN: begin
					cnt_q <= '0;
					piv_q <= piv_q + cnt_t'(1);
				end
				ST_OUT_CAP: begin
					cnt_q <= cnt_q + cnt_t'(1);
					if (last_cnt) fill_q <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= raddr;
		if (op_s1 == OP_PIVOT) prow_q <= rdata;
		if (op_s1 == OP_EMIT) begin
			out_idx_q   <= ridx_t'(addr_s1);
			out_bits_q  <= rdata & geom.cmask;
			out_final_q <= last_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (op_s1 == OP_EMIT) begin
			out_vld_q <= 1'b1;
		end else if (row_out.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign row_out.valid       = out_vld_q;
	assign row_out.row_index   = out_idx_q;
	assign row_out.closed_bits = out_bits_q;
	assign row_out.final_row   = out_final_q;

`ifndef SYNTHESIS
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		!(we && re && (waddr == raddr)))
		else $error("read and write of the same row in one cycle");
	a_out_reg_free: assert property (@(posedge clk) disable iff (!arst_n)
		(op_s1 == OP_EMIT) |-> !out_vld_q)
		else $error("output register overwritten");
	a_pivot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STREAM) |-> (piv_q < geom.diag))
		else $error("pivot beyond diagonal");
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= cnt_t'(DEPTH))
		else $error("fill count beyond memory depth");
`endif

endmodule

### hdl/boolean_matrix_closure.sv
// Sequence: for R rows and D = min(rows, cols), the last item is followed by a prep sweep over
// the R rows, D pivot passes over the R rows in transitive modes, then rows are read out in turn.
// A new matrix is taken only once the last row of the current one has been captured for output;
// the single read and single write port of the row memory set the throughput.
// Reset: control state clears, counts go to 16 and the mode to transitive; the row memory
// is not cleared, since rows not loaded in a matrix read as zero through the fill count.
`timescale 1ns / 1ps

module boolean_matrix_closure #(
	parameter int MAX_NODES = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	bmc_cfg_if.sink        cfg,
	bmc_row_in_if.sink     row_in,
	bmc_row_out_if.source  row_out
);
	import bmc_pkg::*;

	localparam int Depth = (MAX_NODES < ROW_W) ? MAX_NODES : ROW_W;

	geom_t geom;

	bmc_cfg #(.DEPTH(Depth)) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.geom   (geom)
	);

	bmc_engine #(.DEPTH(Depth)) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.geom    (geom),
		.row_in  (row_in),
		.row_out (row_out)
	);

endmodule
